// File: sv/u8lt_pkg.sv
// Shared types and constants for the UTF-8 stream decoder with line tracking.
package u8lt_pkg;

   localparam int CP_W   = 21;
   localparam int LINE_W = 20;
   localparam int COL_W  = 16;
   localparam int ERR_W  = 4;

   // Result queue depth; an item may push two results.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_LEAD    = 4'd1;
   localparam logic [ERR_W-1:0] ERR_PADDED_LEAD = 4'd2;
   localparam logic [ERR_W-1:0] ERR_EOF_IN_SEQ  = 4'd3;
   localparam logic [ERR_W-1:0] ERR_BAD_CONT    = 4'd4;
   localparam logic [ERR_W-1:0] ERR_PADDED_CONT = 4'd5;
   localparam logic [ERR_W-1:0] ERR_SURROGATE   = 4'd6;
   localparam logic [ERR_W-1:0] ERR_RANGE       = 4'd7;
   localparam logic [ERR_W-1:0] ERR_LATE_BOM    = 4'd8;

   localparam logic [CP_W-1:0] CP_LF     = 21'h00000A;
   localparam logic [CP_W-1:0] CP_CR     = 21'h00000D;
   localparam logic [CP_W-1:0] CP_BOM    = 21'h00FEFF;
   localparam logic [CP_W-1:0] CP_SUR_LO = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SUR_HI = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

   localparam logic [7:0] LEAD_MIN     = 8'd192;
   localparam logic [7:0] LEAD_MAX     = 8'd247;
   localparam logic [7:0] LEAD_OK_MIN  = 8'd194;
   localparam logic [7:0] LEAD3_MIN    = 8'd224;
   localparam logic [7:0] LEAD4_MIN    = 8'd240;

   // What one input beat resolves to before CR and BOM handling.
   typedef enum logic [1:0] {
      EV_NONE,
      EV_DELIVER,
      EV_FAIL,
      EV_END
   } event_type;

   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      kind_type          kind;
      logic [ERR_W-1:0]  error_code;
      logic [LINE_W-1:0] line_idx;
      logic [COL_W-1:0]  column;
      logic              last;
   } result_type;

endpackage

// File: sv/u8lt_decode.sv
// Decode state and single-pass step logic: one input beat to zero, one or two results.
module u8lt_decode #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_input,
   output u8lt_pkg::result_type  res0,
   output u8lt_pkg::result_type  res1,
   output logic [1:0]            res_count
);
   import u8lt_pkg::*;

   localparam int LINE_EXT = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
   localparam int COL_EXT  = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;

   logic [CP_W-1:0]        acc_ff, acc_in, acc_next;
   logic [1:0]             rem_ff, rem_in;
   logic                   start_ff, start_in;
   logic                   cr_ff, cr_in;
   kind_type               status_ff, status_in;
   logic [ERR_W-1:0]       err_ff, err_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, line1;
   logic [COLUMN_BITS-1:0] col_ff, col_in, col1;

   event_type              ev;
   logic [CP_W-1:0]        ev_cp;
   logic [ERR_W-1:0]       ev_code;
   logic                   drop_bom, flush;
   logic                   main_vld;
   result_type             lf_res, main_res;

   function automatic logic [LINE_BITS-1:0] line_sat(input logic [LINE_BITS-1:0] v);
      return (v == {LINE_BITS{1'b1}}) ? v : v + LINE_BITS'(1);
   endfunction

   function automatic logic [COLUMN_BITS-1:0] col_sat(input logic [COLUMN_BITS-1:0] v);
      return (v == {COLUMN_BITS{1'b1}}) ? v : v + COLUMN_BITS'(1);
   endfunction

   function automatic logic [LINE_W-1:0] line_field(input logic [LINE_BITS-1:0] v);
      logic [LINE_EXT-1:0] w;
      w = LINE_EXT'(v);
      return w[LINE_W-1:0];
   endfunction

   function automatic logic [COL_W-1:0] col_field(input logic [COLUMN_BITS-1:0] v);
      logic [COL_EXT-1:0] w;
      w = COL_EXT'(v);
      return w[COL_W-1:0];
   endfunction

   // shift in six payload bits; the upper bits fall off at 21
   assign acc_next = {acc_ff[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      start_in  = start_ff;
      cr_in     = cr_ff;
      status_in = status_ff;
      err_in    = err_ff;
      ev        = EV_NONE;
      ev_cp     = '0;
      ev_code   = ERR_NONE;

      // byte classification
      if (status_ff == KIND_CHAR) begin
         if (end_of_input) begin
            if (rem_ff != 2'd0) begin
               ev      = EV_FAIL;
               ev_code = ERR_EOF_IN_SEQ;
            end else begin
               ev = EV_END;
            end
         end else if (rem_ff == 2'd0) begin
            if (!data_byte[7]) begin
               ev    = EV_DELIVER;
               ev_cp = CP_W'(data_byte);
            end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
               ev      = EV_FAIL;
               ev_code = ERR_BAD_LEAD;
            end else if (data_byte < LEAD_OK_MIN) begin
               ev      = EV_FAIL;
               ev_code = ERR_PADDED_LEAD;
            end else if (data_byte < LEAD3_MIN) begin
               acc_in = CP_W'(data_byte[4:0]);
               rem_in = 2'd1;
            end else if (data_byte < LEAD4_MIN) begin
               acc_in = CP_W'(data_byte[3:0]);
               rem_in = 2'd2;
            end else begin
               acc_in = CP_W'(data_byte[2:0]);
               rem_in = 2'd3;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            ev      = EV_FAIL;
            ev_code = ERR_BAD_CONT;
         end else if (acc_next == '0) begin
            ev      = EV_FAIL;
            ev_code = ERR_PADDED_CONT;
         end else begin
            acc_in = acc_next;
            rem_in = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               if (acc_next >= CP_SUR_LO && acc_next <= CP_SUR_HI) begin
                  ev      = EV_FAIL;
                  ev_code = ERR_SURROGATE;
               end else if (acc_next > CP_MAX) begin
                  ev      = EV_FAIL;
                  ev_code = ERR_RANGE;
               end else begin
                  ev    = EV_DELIVER;
                  ev_cp = acc_next;
               end
            end
         end
      end

      // pending CR turns into LF ahead of anything but a dropped leading BOM
      drop_bom = start_ff && (ev_cp == CP_BOM);
      flush    = cr_ff && ((ev == EV_FAIL) || (ev == EV_END) ||
                           ((ev == EV_DELIVER) && !drop_bom));
      line1    = flush ? line_sat(line_ff) : line_ff;
      col1     = flush ? '0 : col_ff;
      if (flush) begin
         cr_in = 1'b0;
      end
      line_in  = line1;
      col_in   = col1;

      main_vld = 1'b0;
      main_res = '{code_point: '0, kind: KIND_CHAR, error_code: ERR_NONE,
                   line_idx: '0, column: '0, last: 1'b1};

      case (ev)
         EV_FAIL: begin
            main_vld            = 1'b1;
            main_res.kind       = KIND_ERROR;
            main_res.error_code = ev_code;
            status_in           = KIND_ERROR;
            err_in              = ev_code;
            start_in            = 1'b0;
            rem_in              = 2'd0;
         end
         EV_END: begin
            main_vld      = 1'b1;
            main_res.kind = KIND_END;
            status_in     = KIND_END;
            err_in        = ERR_NONE;
         end
         EV_DELIVER: begin
            start_in = 1'b0;
            if (drop_bom) begin
               main_vld = 1'b0;
            end else if (flush && ev_cp == CP_LF) begin
               main_vld = 1'b0;    // LF of a CR LF pair
            end else if (ev_cp == CP_CR) begin
               cr_in = 1'b1;
            end else if (ev_cp == CP_BOM) begin
               main_vld            = 1'b1;
               main_res.kind       = KIND_ERROR;
               main_res.error_code = ERR_LATE_BOM;
               status_in           = KIND_ERROR;
               err_in              = ERR_LATE_BOM;
            end else begin
               main_vld            = 1'b1;
               main_res.code_point = ev_cp;
               if (ev_cp == CP_LF) begin
                  line_in = line_sat(line1);
                  col_in  = '0;
               end else begin
                  col_in  = col_sat(col1);
               end
            end
         end
         default: begin
            main_vld = 1'b0;
         end
      endcase

      main_res.line_idx = line_field(line_in);
      main_res.column   = col_field(col_in);

      lf_res = '{code_point: CP_LF, kind: KIND_CHAR, error_code: ERR_NONE,
                 line_idx: line_field(line1), column: col_field(col1),
                 last: !main_vld};

      if (status_ff != KIND_CHAR) begin
         // sticky: repeat the final status, counters frozen
         res0 = '{code_point: '0, kind: status_ff, error_code: err_ff,
                  line_idx: line_field(line_ff), column: col_field(col_ff),
                  last: 1'b1};
         res1      = main_res;
         res_count = 2'd1;
      end else if (flush) begin
         res0      = lf_res;
         res1      = main_res;
         res_count = main_vld ? 2'd2 : 2'd1;
      end else begin
         res0      = main_res;
         res1      = main_res;
         res_count = main_vld ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         rem_ff    <= 2'd0;
         start_ff  <= 1'b1;
         cr_ff     <= 1'b0;
         status_ff <= KIND_CHAR;
         err_ff    <= ERR_NONE;
         line_ff   <= LINE_BITS'(1);
         col_ff    <= '0;
      end else if (accept) begin
         acc_ff    <= acc_in;
         rem_ff    <= rem_in;
         start_ff  <= start_in;
         cr_ff     <= cr_in;
         status_ff <= status_in;
         err_ff    <= err_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
      end
   end

endmodule

// File: sv/u8lt_rsp_queue.sv
// Small result queue: takes up to two results per cycle, hands out one.
module u8lt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [1:0]            push_count,
   input  u8lt_pkg::result_type  push0,
   input  u8lt_pkg::result_type  push1,
   input  logic                  pop,
   output u8lt_pkg::result_type  head,
   output logic                  head_valid,
   output logic                  room
);
   import u8lt_pkg::*;

   result_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, wr_ptr_nxt;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic [1:0]         n_push;

   assign n_push     = push ? push_count : 2'd0;
   assign wr_ptr_nxt = wr_ptr_ff + QPTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + QPTR_W'(n_push);
   assign rd_ptr_in  = rd_ptr_ff + QPTR_W'(pop);
   assign count_in   = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   // room for the worst case of two results
   assign room       = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         entry_ff[wr_ptr_nxt] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/utf8_stream_decoder_line_tracker.sv
// Top level: validating UTF-8 stream decoder with CR/LF folding and line/column tracking.
//
// Input channel (req_): one beat carries a raw byte, or an end-of-input mark
// (req_end_of_input high, req_data_byte ignored).
// Result channel (rsp_): one beat per decoded code point, end result or error
// result, with the line and column after that result; rsp_last_of_run marks
// the last result caused by one input beat. An input beat yields 0, 1 or 2
// results (a held CR is released as LF ahead of the next result).
// Results enter the queue as their input beat is taken and are presented from
// the queue head register. Throughput: one input beat per cycle while the
// receiver takes results and each beat yields at most one result; a beat that
// yields two takes a result beat for each. The decode step is a single pass of
// compare and shift logic on the state registers; results go into a four-entry
// queue, and req_ready stays high as long as two entries are free, so a stalled
// receiver backs up into req_ready after at most a few beats without losing anything.
// Reset: synchronous; empties the queue, clears the decode state, sets the
// line to 1 and column to 0. After an end or error result every later input
// beat gets one copy of that result until reset.
module utf8_stream_decoder_line_tracker #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_result_kind,
   output logic [3:0]  rsp_error_code,
   output logic [19:0] rsp_line_idx,
   output logic [15:0] rsp_column,
   output logic        rsp_last_of_run
);
   import u8lt_pkg::*;

   logic       req_accept;
   logic       rsp_accept;
   result_type dec_res0, dec_res1, head;
   logic [1:0] dec_count;
   logic       room;

   assign req_ready  = room;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;

   u8lt_decode #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .end_of_input (req_end_of_input),
      .res0         (dec_res0),
      .res1         (dec_res1),
      .res_count    (dec_count)
   );

   u8lt_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_count (dec_count),
      .push0      (dec_res0),
      .push1      (dec_res1),
      .pop        (rsp_accept),
      .head       (head),
      .head_valid (rsp_valid),
      .room       (room)
   );

   // result beat fields straight from the queue head register
   assign rsp_code_point  = head.code_point;
   assign rsp_result_kind = head.kind;
   assign rsp_error_code  = head.error_code;
   assign rsp_line_idx    = head.line_idx;
   assign rsp_column      = head.column;
   assign rsp_last_of_run = head.last;

endmodule

// File: sv/u8lt_checker.sv
// Port-level checker for the decoder, bound to the top level.
module u8lt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_point,
   input logic [1:0]  rsp_result_kind,
   input logic [3:0]  rsp_error_code,
   input logic [19:0] rsp_line_idx,
   input logic [15:0] rsp_column,
   input logic        rsp_last_of_run
);
   import u8lt_pkg::*;

   logic        rsp_accept;
   logic        final_seen_ff;
   logic [1:0]  final_kind_ff;
   logic [3:0]  final_err_ff;
   logic [19:0] final_line_ff;
   logic [15:0] final_col_ff;

   assign rsp_accept = rsp_valid && rsp_ready;

   // remember the first end or error result delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         final_seen_ff <= 1'b0;
      end else if (rsp_accept && !final_seen_ff &&
                   rsp_result_kind != KIND_CHAR) begin
         final_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_accept && !final_seen_ff) begin
         final_kind_ff <= rsp_result_kind;
         final_err_ff  <= rsp_error_code;
         final_line_ff <= rsp_line_idx;
         final_col_ff  <= rsp_column;
      end
   end

   a_sticky_status: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && final_seen_ff |->
         rsp_result_kind == final_kind_ff && rsp_error_code == final_err_ff)
      else $error("status changed after end or error result");

   a_frozen_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && final_seen_ff |->
         rsp_line_idx == final_line_ff && rsp_column == final_col_ff)
      else $error("counters moved after end or error result");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point) &&
         $stable(rsp_result_kind) && $stable(rsp_last_of_run))
      else $error("stalled result beat dropped or changed");

endmodule

bind utf8_stream_decoder_line_tracker u8lt_checker u_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the UTF-8 stream decoder with CR/LF folding and line tracking.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import u8lt_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_BEATS = 1700;  // least number of input beats sent by the end of the random part
   localparam int COL_RUN      = 100;   // printable bytes in the long gap-free line
   localparam int HOLD_AT      = 300;   // result count at which the receiver stalls long
   localparam int HOLD_LEN     = 200;   // length of that stall, in cycles
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side before giving up
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 200;

   // Code points right at the UTF-8 length and range boundaries.
   localparam logic [CP_W-1:0] CP_BOUNDS [10] = '{
      21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
      21'h00E000, 21'h00FFFD, 21'h00FFFF, 21'h010000, 21'h10FFFF
   };

   // One input beat; where typed is set, the last result it causes is pinned
   // to cp/kind/err instead of taking those fields from the decoder model.
   typedef struct packed {
      logic [7:0]      data;
      logic            eoi;
      logic            typed;
      logic [CP_W-1:0] cp;
      kind_type        kind;
      logic [ERR_W-1:0] err;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic [1:0]  rsp_result_kind;
   logic [3:0]  rsp_error_code;
   logic [19:0] rsp_line_idx;
   logic [15:0] rsp_column;
   logic        rsp_last_of_run;

   utf8_stream_decoder_line_tracker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_line_idx     (rsp_line_idx),
      .rsp_column       (rsp_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder model: its own copy of the sequence state and the counters.
   // ---------------------------------------------------------------------
   logic [CP_W-1:0]   acc_bits;
   logic [1:0]        cont_left;    // continuation bytes still owed
   bit                first_cp;     // no code point completed yet
   bit                cr_held;      // CR seen, LF not yet released
   kind_type          stuck_kind;   // KIND_CHAR while the stream is still live
   logic [ERR_W-1:0]  stuck_code;
   logic [LINE_W-1:0] line_cnt;
   logic [COL_W-1:0]  col_cnt;

   result_type step_out[$];     // results of the beat being decoded
   result_type results_due[$];  // decoded results the block still owes us

   int  bytes_sent = 0;
   int  results_seen = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   bit  no_gaps = 1'b0;         // both sides run flat out while set

   function automatic void put(logic [CP_W-1:0] cp, kind_type kind, logic [ERR_W-1:0] err);
      result_type r;
      r.code_point  = cp;
      r.kind        = kind;
      r.error_code  = err;
      r.line_idx    = line_cnt;
      r.column      = col_cnt;
      r.last        = 1'b0;
      step_out.push_back(r);
   endfunction

   // LF opens a new line; anything else moves the column. Both saturate.
   function automatic void emit_char(logic [CP_W-1:0] cp);
      if (cp == CP_LF) begin
         if (line_cnt != '1) line_cnt++;
         col_cnt = '0;
      end else if (col_cnt != '1) begin
         col_cnt++;
      end
      put(cp, KIND_CHAR, ERR_NONE);
   endfunction

   function automatic void release_cr();
      if (cr_held) begin
         cr_held = 1'b0;
         emit_char(CP_LF);
      end
   endfunction

   function automatic void raise_error(logic [ERR_W-1:0] code);
      release_cr();
      first_cp   = 1'b0;
      cont_left  = '0;
      stuck_kind = KIND_ERROR;
      stuck_code = code;
      put('0, KIND_ERROR, code);
   endfunction

   // A completed code point: BOM and CR handling before it counts as a char.
   function automatic void deliver_cp(logic [CP_W-1:0] cp);
      if (first_cp) begin
         first_cp = 1'b0;
         if (cp == CP_BOM) return;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         emit_char(CP_LF);
         if (cp == CP_LF) return;
      end
      if (cp == CP_CR) begin
         cr_held = 1'b1;
         return;
      end
      if (cp == CP_BOM) begin
         raise_error(ERR_LATE_BOM);
         return;
      end
      emit_char(cp);
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      if (cont_left == 0) begin
         if (b < 8'd128) begin
            deliver_cp({13'd0, b});
         end else if (b < LEAD_MIN || b > LEAD_MAX) begin
            raise_error(ERR_BAD_LEAD);
         end else if (b < LEAD3_MIN) begin
            if (b < LEAD_OK_MIN) begin
               raise_error(ERR_PADDED_LEAD);
            end else begin
               acc_bits  = {16'd0, b[4:0]};
               cont_left = 2'd1;
            end
         end else if (b < LEAD4_MIN) begin
            acc_bits  = {17'd0, b[3:0]};
            cont_left = 2'd2;
         end else begin
            acc_bits  = {18'd0, b[2:0]};
            cont_left = 2'd3;
         end
         return;
      end
      if (b[7:6] != 2'b10) begin
         raise_error(ERR_BAD_CONT);
         return;
      end
      acc_bits = {acc_bits[14:0], b[5:0]};
      if (acc_bits == '0) begin
         raise_error(ERR_PADDED_CONT);
         return;
      end
      cont_left--;
      if (cont_left != 0) return;
      if (acc_bits >= CP_SUR_LO && acc_bits <= CP_SUR_HI) raise_error(ERR_SURROGATE);
      else if (acc_bits > CP_MAX) raise_error(ERR_RANGE);
      else deliver_cp(acc_bits);
   endfunction

   // Fills step_out with what one accepted beat must produce.
   function automatic void decode_item(logic [7:0] b, logic eoi);
      result_type r;
      step_out = {};
      if (stuck_kind != KIND_CHAR) begin
         put('0, stuck_kind, stuck_code);
      end else if (eoi) begin
         if (cont_left != 0) begin
            raise_error(ERR_EOF_IN_SEQ);
         end else begin
            release_cr();
            stuck_kind = KIND_END;
            stuck_code = ERR_NONE;
            put('0, KIND_END, ERR_NONE);
         end
      end else begin
         decode_byte(b);
      end
      if (step_out.size() != 0) begin
         r = step_out[step_out.size() - 1];
         r.last = 1'b1;
         step_out[step_out.size() - 1] = r;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus rows
   // ---------------------------------------------------------------------
   function automatic stim_type plain(logic [7:0] b);
      return '{b, 1'b0, 1'b0, '0, KIND_CHAR, ERR_NONE};
   endfunction

   function automatic stim_type char_row(logic [7:0] b, logic [CP_W-1:0] cp);
      return '{b, 1'b0, 1'b1, cp, KIND_CHAR, ERR_NONE};
   endfunction

   function automatic stim_type closing_row(logic [7:0] b, logic eoi, kind_type kind,
                                            logic [ERR_W-1:0] err);
      return '{b, eoi, 1'b1, '0, kind, err};
   endfunction

   // Well-formed code point, weighted toward CR/LF and length boundaries.
   // Surrogates and U+FEFF are kept out: either would end the stream.
   function automatic logic [CP_W-1:0] pick_cp();
      logic [CP_W-1:0] cp;
      case ($urandom_range(0, 9))
         0: cp = CP_CR;
         1: cp = CP_LF;
         2, 3, 4: cp = CP_W'($urandom_range(0, 127));
         5, 6: cp = CP_W'($urandom_range(128, 2047));
         7: begin
            cp = CP_W'($urandom_range(32'h0800, 32'hFFFF));
            if ((cp >= CP_SUR_LO && cp <= CP_SUR_HI) || cp == CP_BOM) cp = 21'h00E000;
         end
         8: cp = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
         default: cp = CP_BOUNDS[$urandom_range(0, 9)];
      endcase
      return cp;
   endfunction

   // Offer one beat, hold it until taken, then book the results it owes us.
   task automatic send_row(input stim_type row);
      int gap;
      result_type r;
      // every third stretch of 150 beats goes without gaps
      if (no_gaps || (bytes_sent / 150) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= row.data;
      req_end_of_input <= row.eoi;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      decode_item(row.data, row.eoi);
      if (row.typed && step_out.size() != 0) begin
         r = step_out[step_out.size() - 1];
         r.code_point = row.cp;
         r.kind       = row.kind;
         r.error_code = row.err;
         step_out[step_out.size() - 1] = r;
      end
      foreach (step_out[i]) results_due.push_back(step_out[i]);
   endtask

   task automatic send_cp(input logic [CP_W-1:0] cp);
      if (cp < 21'h80) begin
         send_row(plain(cp[7:0]));
      end else if (cp < 21'h800) begin
         send_row(plain({3'b110, cp[10:6]}));
         send_row(plain({2'b10, cp[5:0]}));
      end else if (cp < 21'h10000) begin
         send_row(plain({4'b1110, cp[15:12]}));
         send_row(plain({2'b10, cp[11:6]}));
         send_row(plain({2'b10, cp[5:0]}));
      end else begin
         send_row(plain({5'b11110, cp[20:18]}));
         send_row(plain({2'b10, cp[17:12]}));
         send_row(plain({2'b10, cp[11:6]}));
         send_row(plain({2'b10, cp[5:0]}));
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_type         intro_rows[$];
      stim_type         tail_rows[$];
      logic [ERR_W-1:0] ending;
      logic [7:0]       lead;
      kind_type         stuck;

      acc_bits   = '0;
      cont_left  = '0;
      first_cp   = 1'b1;
      cr_held    = 1'b0;
      stuck_kind = KIND_CHAR;
      stuck_code = ERR_NONE;
      line_cnt   = LINE_W'(1);
      col_cnt    = '0;

      // Leading BOM (dropped), then the shortest form of each sequence length, the
      // longest one-, three- and four-byte forms, CR LF folding and back-to-back CRs.
      intro_rows = '{
         plain(8'hEF), plain(8'hBB), plain(8'hBF),
         char_row(8'h00, 21'h000000),
         char_row(8'h7F, 21'h00007F),
         plain(8'hC2), char_row(8'h80, 21'h000080),
         plain(8'hE0), plain(8'hA0), char_row(8'h80, 21'h000800),
         plain(8'hEF), plain(8'hBF), char_row(8'hBF, 21'h00FFFF),
         plain(8'hF0), plain(8'h90), plain(8'h80), char_row(8'h80, 21'h010000),
         plain(8'hF4), plain(8'h8F), plain(8'hBF), char_row(8'hBF, CP_MAX),
         plain(8'h0D), char_row(8'h0A, CP_LF),
         plain(8'h0D), plain(8'h0D), plain(8'h41)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (intro_rows[i]) send_row(intro_rows[i]);

      // Random well-formed text. A malformed byte would freeze the stream,
      // so broken sequences are saved for the very end.
      while (bytes_sent < RANDOM_BEATS) send_cp(pick_cp());

      // Let the block run dry before the next phase.
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);

      // One long line with no gaps on either side, then LF brings the
      // column back to zero.
      no_gaps = 1'b1;
      repeat (COL_RUN) send_row(plain(8'($urandom_range(32, 126))));
      send_row(plain(CP_LF[7:0]));
      no_gaps = 1'b0;

      // Finish the stream with one randomly chosen error or a clean end,
      // sometimes with a CR still held so the LF is released ahead of it.
      ending = ERR_W'($urandom_range(0, 8));
      if ($urandom_range(0, 1)) tail_rows.push_back(plain(CP_CR[7:0]));
      case (ending)
         ERR_BAD_LEAD:
            tail_rows.push_back(closing_row($urandom_range(0, 1) ?
               8'($urandom_range(128, 191)) : 8'($urandom_range(248, 255)),
               1'b0, KIND_ERROR, ERR_BAD_LEAD));
         ERR_PADDED_LEAD:
            tail_rows.push_back(closing_row(8'hC0 | 8'($urandom_range(0, 1)), 1'b0,
                                            KIND_ERROR, ERR_PADDED_LEAD));
         ERR_EOF_IN_SEQ: begin
            tail_rows.push_back(plain(8'($urandom_range(194, 247))));
            tail_rows.push_back(closing_row(8'($urandom), 1'b1, KIND_ERROR, ERR_EOF_IN_SEQ));
         end
         ERR_BAD_CONT: begin
            tail_rows.push_back(plain(8'($urandom_range(194, 247))));
            tail_rows.push_back(closing_row($urandom_range(0, 1) ?
               8'($urandom_range(0, 127)) : 8'($urandom_range(192, 255)),
               1'b0, KIND_ERROR, ERR_BAD_CONT));
         end
         ERR_PADDED_CONT: begin
            // overlong form whose payload is all zero after the first continuation
            tail_rows.push_back(plain($urandom_range(0, 1) ? 8'hE0 : 8'hF0));
            tail_rows.push_back(closing_row(8'h80, 1'b0, KIND_ERROR, ERR_PADDED_CONT));
         end
         ERR_SURROGATE: begin
            tail_rows.push_back(plain(8'hED));
            tail_rows.push_back(plain(8'hA0 | 8'($urandom_range(0, 31))));
            tail_rows.push_back(closing_row(8'h80 | 8'($urandom_range(0, 63)), 1'b0,
                                            KIND_ERROR, ERR_SURROGATE));
         end
         ERR_RANGE: begin
            lead = 8'($urandom_range(244, 247));
            tail_rows.push_back(plain(lead));
            tail_rows.push_back(plain(lead == 8'hF4 ? 8'($urandom_range(144, 191)) :
                                                      8'($urandom_range(128, 191))));
            tail_rows.push_back(plain(8'($urandom_range(128, 191))));
            tail_rows.push_back(closing_row(8'($urandom_range(128, 191)), 1'b0,
                                            KIND_ERROR, ERR_RANGE));
         end
         ERR_LATE_BOM: begin
            tail_rows.push_back(plain(8'hEF));
            tail_rows.push_back(plain(8'hBB));
            tail_rows.push_back(closing_row(8'hBF, 1'b0, KIND_ERROR, ERR_LATE_BOM));
         end
         default:
            tail_rows.push_back(closing_row(8'($urandom), 1'b1, KIND_END, ERR_NONE));
      endcase

      // Whatever follows must repeat the final status, counters frozen.
      stuck = (ending == ERR_NONE) ? KIND_END : KIND_ERROR;
      repeat (4) tail_rows.push_back(closing_row(8'($urandom), 1'($urandom_range(0, 1)),
                                                 stuck, ending));

      foreach (tail_rows[i]) send_row(tail_rows[i]);

      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   initial begin : drain_results
      int         stall;
      result_type want;

      do @(posedge clock); while (reset);
      forever begin
         // One long hold-off so the result queue fills and req_ready drops;
         // otherwise random stalls, with every third stretch of 150 stall-free.
         if (results_seen == HOLD_AT) stall = HOLD_LEN;
         else if (no_gaps || (results_seen / 150) % 3 == 2) stall = 0;
         else stall = $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $error("result beat with nothing expected: kind %0d code point 0x%0h",
                      rsp_result_kind, rsp_code_point);
         end else begin
            want = results_due.pop_front();
            check_field("code_point",  32'(want.code_point), 32'(rsp_code_point));
            check_field("result_kind", 32'(want.kind),       32'(rsp_result_kind));
            check_field("error_code",  32'(want.error_code), 32'(rsp_error_code));
            check_field("line_idx",    32'(want.line_idx),   32'(rsp_line_idx));
            check_field("column",      32'(want.column),     32'(rsp_column));
            check_field("last_of_run", 32'(want.last),       32'(rsp_last_of_run));
         end
      end
   end

   // Watchdog: too long with no beat on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
